FILE: hdl/pftr_pkg.sv
// Shared types and constants for the pixel format to RGB888 converter.
`timescale 1ns / 1ps

package pftr_pkg;

    // Source pixel format codes held in the format register
    typedef enum logic [1:0] {
        FMT_RGB888   = 2'd0,
        FMT_RGB565   = 2'd1,
        FMT_BGR888   = 2'd2,
        FMT_RGBA8888 = 2'd3
    } t_fmt;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned HELD_W  = 3 * BYTE_W;
    localparam int unsigned PHASE_W = 2;

    // Index of the last byte of a source pixel
    localparam logic [PHASE_W-1:0] LAST_2B = 2'd1;
    localparam logic [PHASE_W-1:0] LAST_3B = 2'd2;
    localparam logic [PHASE_W-1:0] LAST_4B = 2'd3;

    // A whole source pixel: three held bytes plus the completing byte
    typedef struct packed {
        t_fmt              fmt;
        logic [BYTE_W-1:0] b3;
        logic [BYTE_W-1:0] b2;
        logic [BYTE_W-1:0] b1;
        logic [BYTE_W-1:0] b0;
    } t_raw_pix;

endpackage

FILE: hdl/pftr_if.sv
// Valid/ready channel interfaces for the raw byte input and the RGB888 output.
`timescale 1ns / 1ps

interface pftr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, output data_byte, output end_of_frame, input ready);
    modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface pftr_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: hdl/pftr_assemble.sv
// Byte phase tracking and source pixel assembly into the first pipeline stage.
`timescale 1ns / 1ps

module pftr_assemble (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_wdata,
    pftr_byte_if.sink           i_byte,
    input  logic                i_take,
    output logic                o_s1_vld,
    output pftr_pkg::t_raw_pix  o_s1
);

    pftr_pkg::t_fmt                      r_fmt, n_fmt;
    logic [pftr_pkg::PHASE_W-1:0]        r_phase, n_phase;
    logic [pftr_pkg::HELD_W-1:0]         r_held, n_held;
    logic                                r_s1_vld, n_s1_vld;
    pftr_pkg::t_raw_pix                  r_s1;
    logic [pftr_pkg::PHASE_W-1:0]        w_last;
    logic                                w_accept;
    logic                                w_complete;

    // Stage 1 frees up when empty or when the output stage takes it
    assign i_byte.ready = !r_s1_vld || i_take;
    assign w_accept     = i_byte.valid && i_byte.ready;

    // Last byte index of the current format
    always_comb begin
        unique case (r_fmt)
            pftr_pkg::FMT_RGB565:   w_last = pftr_pkg::LAST_2B;
            pftr_pkg::FMT_RGBA8888: w_last = pftr_pkg::LAST_4B;
            pftr_pkg::FMT_RGB888,
            pftr_pkg::FMT_BGR888:   w_last = pftr_pkg::LAST_3B;
        endcase
    end

    assign w_complete = (r_phase >= w_last);

    // Phase and held byte update
    always_comb begin
        n_fmt   = r_fmt;
        n_phase = r_phase;
        n_held  = r_held;
        if (i_cfg_we) begin
            n_fmt   = pftr_pkg::t_fmt'(i_cfg_wdata);
            n_phase = '0;
            n_held  = '0;
        end else if (w_accept) begin
            if (w_complete) begin
                n_phase = '0;
                n_held  = '0;
            end else begin
                case (r_phase)
                    2'd0:    n_held[7:0]   = i_byte.data_byte;
                    2'd1:    n_held[15:8]  = i_byte.data_byte;
                    default: n_held[23:16] = i_byte.data_byte;
                endcase
                n_phase = r_phase + 2'd1;
            end
            if (i_byte.end_of_frame) begin
                n_phase = '0;
                n_held  = '0;
            end
        end
    end

    // Stage 1 valid: set on a completed pixel, cleared when taken
    always_comb begin
        if (w_accept && w_complete) begin
            n_s1_vld = 1'b1;
        end else if (i_take) begin
            n_s1_vld = 1'b0;
        end else begin
            n_s1_vld = r_s1_vld;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= pftr_pkg::FMT_RGB888;
            r_phase  <= '0;
            r_held   <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            r_fmt    <= n_fmt;
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_s1_vld <= n_s1_vld;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_complete) begin
            r_s1.fmt <= r_fmt;
            r_s1.b0  <= r_held[7:0];
            r_s1.b1  <= r_held[15:8];
            r_s1.b2  <= r_held[23:16];
            r_s1.b3  <= i_byte.data_byte;
        end
    end

    assign o_s1_vld = r_s1_vld;
    assign o_s1     = r_s1;

`ifndef SYNTHESIS
    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= w_last)
        else $error("byte phase beyond last byte of format");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_phase == '0) && (r_held == '0))
        else $error("format write did not clear pixel state");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_byte.end_of_frame) |=> (r_phase == '0) && (r_held == '0))
        else $error("end of frame did not clear pixel state");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !i_take) |=> r_s1_vld && $stable(r_s1))
        else $error("stage 1 pixel lost while stalled");
`endif

endmodule

FILE: hdl/pftr_convert.sv
// Component extraction, RGB565 widening and the output register.
`timescale 1ns / 1ps

module pftr_convert (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s1_vld,
    input  pftr_pkg::t_raw_pix  i_s1,
    output logic                o_take,
    pftr_pix_if.source          o_pix
);

    logic       r_vld;
    logic [7:0] r_red, r_green, r_blue;
    logic [7:0] n_red, n_green, n_blue;
    logic [15:0] w_word;

    // Rounded (v*255 + 15) / 31; reciprocal estimate is low by at most one
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [12:0] x;
        logic [17:0] p;
        logic [7:0]  q;
        logic [12:0] r;
        x = 13'(v) * 13'd255 + 13'd15;
        p = 18'(x) * 18'd33;
        q = p[17:10];
        r = x - 13'(q) * 13'd31;
        if (r >= 13'd31) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

    // Rounded (v*255 + 31) / 63, same correction scheme
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [13:0] x;
        logic [19:0] p;
        logic [7:0]  q;
        logic [13:0] r;
        x = 14'(v) * 14'd255 + 14'd31;
        p = 20'(x) * 20'd65;
        q = p[19:12];
        r = x - 14'(q) * 14'd63;
        if (r >= 14'd63) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

    // Output stage takes a new pixel when empty or being drained
    assign o_take = !r_vld || o_pix.ready;
    assign w_word = {i_s1.b3, i_s1.b0};

    // Format decode
    always_comb begin
        unique case (i_s1.fmt)
            pftr_pkg::FMT_RGB565: begin
                n_red   = widen5(w_word[15:11]);
                n_green = widen6(w_word[10:5]);
                n_blue  = widen5(w_word[4:0]);
            end
            pftr_pkg::FMT_BGR888: begin
                n_red   = i_s1.b3;
                n_green = i_s1.b1;
                n_blue  = i_s1.b0;
            end
            pftr_pkg::FMT_RGBA8888: begin
                n_red   = i_s1.b0;
                n_green = i_s1.b1;
                n_blue  = i_s1.b2;
            end
            pftr_pkg::FMT_RGB888: begin
                n_red   = i_s1.b0;
                n_green = i_s1.b1;
                n_blue  = i_s1.b3;
            end
        endcase
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_s1_vld;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_take && i_s1_vld) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_pix.valid = r_vld;
    assign o_pix.red   = r_red;
    assign o_pix.green = r_green;
    assign o_pix.blue  = r_blue;

`ifndef SYNTHESIS
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !o_pix.ready) |=> r_vld && $stable({r_red, r_green, r_blue}))
        else $error("output stage accepted over a stalled pixel");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_s1_vld) |=> r_vld)
        else $error("taken pixel not shown at the output");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !i_s1_vld) |=> !r_vld)
        else $error("output valid without a pixel");
`endif

endmodule

FILE: hdl/pixel_format_to_rgb888_top.sv
// Top level of the pixel format to RGB888 converter.
// Usage:
//   i_byte is a valid/ready channel of raw source bytes, each with an
//   end_of_frame flag on the frame's last byte. o_pix is a valid/ready
//   channel of RGB888 pixels, one per completed source pixel.
//   i_cfg_we / i_cfg_wdata write the source format (0 rgb888, 1 rgb565
//   little endian, 2 bgr888, 3 rgba8888); a write also drops any partial
//   pixel. Write it only while no transaction is in flight.
// Throughput: one byte transaction per cycle while i_byte.ready is high,
//   set by the byte phase update; one pixel per 2 to 4 bytes by format.
// Path: a pixel's last byte is taken into the assembly register, then
//   the pixel passes RGB565 widening into the output register, which
//   drives o_pix and takes it only while not holding a stalled pixel.
// Reset: synchronous, active low; format returns to rgb888 and the byte
//   phase, held bytes and both stages' valid flags are cleared.
// Stall: while o_pix is held off, the output register keeps its pixel and
//   one more pixel waits in the assembly stage; once both are full,
//   i_byte.ready drops and no byte is taken until the output drains.
`timescale 1ns / 1ps

module pixel_format_to_rgb888_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    pftr_byte_if.sink   i_byte,
    pftr_pix_if.source  o_pix
);

    logic               w_take;
    logic               w_s1_vld;
    pftr_pkg::t_raw_pix w_s1;

    // Byte assembly
    pftr_assemble u_assemble (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (i_byte),
        .i_take      (w_take),
        .o_s1_vld    (w_s1_vld),
        .o_s1        (w_s1)
    );

    // Conversion and output register
    pftr_convert u_convert (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1_vld (w_s1_vld),
        .i_s1     (w_s1),
        .o_take   (w_take),
        .o_pix    (o_pix)
    );

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the pixel format to RGB888 converter.
`timescale 1ns / 1ps

module testbench;

    // Full-scale values of the RGB565 fields
    localparam int unsigned MAX_5B = 31;
    localparam int unsigned MAX_6B = 63;
    // Cycles for a byte in flight to settle before a format write
    localparam int PIPE_SETTLE = 6;
    localparam int RANDOM_PHASES = 8;
    localparam int BYTES_PER_PHASE = 110;
    localparam int LONG_HOLD = 80;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_px;

    // Tracks format, byte phase and held bytes; queues and checks pixels
    class pixel_checker;
        pftr_pkg::t_fmt fmt;
        logic [1:0]     phase;
        logic [23:0]    held;
        t_rgb_px        expected_pixels[$];
        int             errors;
        int             bytes_taken;
        int             pixels_checked;
        int             pixels_by_fmt[4];

        function new();
            fmt = pftr_pkg::FMT_RGB888;
            phase = '0;
            held = '0;
            errors = 0;
            bytes_taken = 0;
            pixels_checked = 0;
            foreach (pixels_by_fmt[i]) pixels_by_fmt[i] = 0;
        endfunction

        function logic [7:0] scale_up(int unsigned v, int unsigned maxv);
            return 8'((v * 255 + maxv / 2) / maxv);
        endfunction

        function void set_format(pftr_pkg::t_fmt f);
            fmt = f;
            phase = '0;
            held = '0;
        endfunction

        // Index of the byte that completes a pixel in the current format
        function logic [1:0] last_index();
            case (fmt)
                pftr_pkg::FMT_RGB565:   return pftr_pkg::LAST_2B;
                pftr_pkg::FMT_RGBA8888: return pftr_pkg::LAST_4B;
                default:                return pftr_pkg::LAST_3B;
            endcase
        endfunction

        function void take_byte(logic [7:0] b, logic eof);
            t_rgb_px     px;
            logic [15:0] word;
            logic [7:0]  b0, b1, b2;
            b0 = held[7:0];
            b1 = held[15:8];
            b2 = held[23:16];
            bytes_taken++;
            if (phase >= last_index()) begin
                case (fmt)
                    pftr_pkg::FMT_RGB565: begin
                        // little endian: first byte is the low half
                        word = {b, b0};
                        px.red   = scale_up(32'(word[15:11]), MAX_5B);
                        px.green = scale_up(32'(word[10:5]), MAX_6B);
                        px.blue  = scale_up(32'(word[4:0]), MAX_5B);
                    end
                    pftr_pkg::FMT_BGR888: begin
                        px = '{red: b, green: b1, blue: b0};
                    end
                    pftr_pkg::FMT_RGBA8888: begin
                        px = '{red: b0, green: b1, blue: b2};
                    end
                    default: begin
                        px = '{red: b0, green: b1, blue: b};
                    end
                endcase
                expected_pixels.push_back(px);
                pixels_by_fmt[fmt]++;
                phase = '0;
                held = '0;
            end else begin
                held[8*phase +: 8] = b;
                phase = phase + 2'd1;
            end
            // end of frame drops any partial pixel
            if (eof) begin
                phase = '0;
                held = '0;
            end
        endfunction

        function void check_pixel(t_rgb_px got);
            t_rgb_px want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.red !== want.red) begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_pixels.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    pftr_byte_if byte_ch ();
    pftr_pix_if  pix_ch ();

    pixel_checker sb;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;

    pixel_format_to_rgb888_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_byte      (byte_ch),
        .o_pix       (pix_ch)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #500000;
        $display("Verification failed");
        $finish;
    end

    // Transaction monitor: format writes, accepted bytes, delivered pixels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_format(pftr_pkg::t_fmt'(i_cfg_wdata));
            if (byte_ch.valid && byte_ch.ready)
                sb.take_byte(byte_ch.data_byte, byte_ch.end_of_frame);
            if (pix_ch.valid && pix_ch.ready)
                sb.check_pixel('{red: pix_ch.red, green: pix_ch.green, blue: pix_ch.blue});
        end
    end

    // Pixel receiver: random stalls, plus long hold-offs on request
    initial begin
        pix_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                pix_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                pix_ch.ready <= ($urandom_range(99, 0) >= sink_stall_pct);
            end
        end
    end

    // Offer one byte; returns on the falling edge after it is taken
    task automatic send_byte(input logic [7:0] data, input logic eof);
        while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.end_of_frame <= eof;
        do @(posedge i_clk); while (!byte_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_format(input pftr_pkg::t_fmt f);
        wait_drained();
        repeat (PIPE_SETTLE) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= f;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pixel_bytes(pftr_pkg::t_fmt f);
        case (f)
            pftr_pkg::FMT_RGB565:   return 2;
            pftr_pkg::FMT_RGBA8888: return 4;
            default:                return 3;
        endcase
    endfunction

    // Random frames: mostly whole pixels, some cut short, some noise
    task automatic run_frames(input pftr_pkg::t_fmt f, input int n_bytes,
                              input bit pause_midway);
        int sent;
        int total;
        int kind;
        int len;
        bit noise;
        bit paused;
        logic eof;
        sent = 0;
        paused = 1'b0;
        len = pixel_bytes(f);
        while (sent < n_bytes) begin
            kind = $urandom_range(9, 0);
            noise = (kind == 0);
            total = $urandom_range(8, 1) * len;
            if (kind == 1)
                total = total - $urandom_range(len - 1, 1);
            if (noise)
                total = $urandom_range(12, 1);
            for (int i = 0; i < total; i++) begin
                eof = (i == total - 1) || (noise && $urandom_range(7, 0) == 0);
                send_byte(8'($urandom_range(255, 0)), eof);
                sent++;
            end
            // sender holds back until every pixel so far is out
            if (pause_midway && !paused && sent >= n_bytes / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        sb = new();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_left = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.end_of_frame <= 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // rgb888 after reset: extremes, eof on a completing byte, dropped tail
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);

        // rgb565: full scale, red plus blue, full green, then a half pixel cut by a write
        write_format(pftr_pkg::FMT_RGB565);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h1F, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'hAB, 1'b0);

        // bgr888 swap
        write_format(pftr_pkg::FMT_BGR888);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hFF, 1'b0);

        // rgba8888 drops alpha
        write_format(pftr_pkg::FMT_RGBA8888);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b1);

        // Random phases over formats and idle patterns
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_format(pftr_pkg::t_fmt'(p % 4));
            case (p / 2)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 9; sink_stall_pct = 9; end
            endcase
            // long receiver hold-off while bytes keep coming: block backs up
            if (p == 1)
                hold_left = LONG_HOLD;
            run_frames(pftr_pkg::t_fmt'(p % 4), BYTES_PER_PHASE, p == 5);
        end

        wait_drained();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (sb.outstanding() != 0) begin
            $error("%0d expected pixels never arrived", sb.outstanding());
            sb.errors++;
        end

        $display("Run covered %0d byte transactions and %0d pixels checked", sb.bytes_taken,
                 sb.pixels_checked);
        $display("Pixels per format rgb888/rgb565/bgr888/rgba8888: %0d/%0d/%0d/%0d",
                 sb.pixels_by_fmt[0], sb.pixels_by_fmt[1], sb.pixels_by_fmt[2],
                 sb.pixels_by_fmt[3]);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/pftr_pkg.sv
hdl/pftr_if.sv
hdl/pftr_assemble.sv
hdl/pftr_convert.sv
hdl/pixel_format_to_rgb888_top.sv
bench/testbench.sv
